[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled during arst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define BMA_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BMA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BMA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/bma_pkg.sv]
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and codes of the buddy allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam int DEF_MAX_ORDER = 10;
	localparam int CFG_RESET_ORDER = 10;
	localparam int CFG_W = 4;
	// holds order+1 for orders up to 30
	localparam int AVAIL_W = 5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	typedef enum logic [1:0] {
		NODE_ABSENT = 2'd0,
		NODE_FREE = 2'd1,
		NODE_OCC = 2'd2,
		NODE_SPLIT = 2'd3
	} node_st_t;

	// avail: 1 + order of the largest free block in the subtree, 0 if none
	typedef struct packed {
		node_st_t st;
		logic [AVAIL_W-1:0] avail;
	} node_t;

	localparam int NODE_W = $bits(node_t);

endpackage

[hdl/bma_ram.sv]
// ----------------------------------------------------------------------------
// bma_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/bma_init.sv]
// ----------------------------------------------------------------------------
// bma_init
// Clearing pass over the node memory: every node absent, the root free.
// ----------------------------------------------------------------------------
module bma_init #(
	parameter int MAX_ORDER = bma_pkg::DEF_MAX_ORDER
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             restart,
	input  logic [$clog2(MAX_ORDER+1)-1:0]   pool_order,
	output logic                             active,
	output logic                             wr_en,
	output logic [MAX_ORDER:0]               wr_addr,
	output bma_pkg::node_t                   wr_data
);

	localparam int IW = MAX_ORDER + 1;

	logic [IW-1:0] cnt_q;
	logic          active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			active_q <= 1'b1;
		end else if (restart) begin
			cnt_q <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				active_q <= 1'b0;
			end
		end
	end

	always_comb begin
		wr_data = '0;
		if (cnt_q == IW'(1)) begin
			wr_data.st = bma_pkg::NODE_FREE;
			wr_data.avail = bma_pkg::AVAIL_W'(pool_order) + 1'b1;
		end
	end

	assign active = active_q;
	assign wr_en = active_q;
	assign wr_addr = cnt_q;

endmodule

[hdl/bma_walk.sv]
// ----------------------------------------------------------------------------
// bma_walk
// Tree walker: descends for allocate or free, then climbs back to the root
// fixing the subtree summaries and merging free buddies.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bma_walk #(
	parameter int MAX_ORDER = bma_pkg::DEF_MAX_ORDER
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic                           op,
	input  logic [MAX_ORDER:0]             request_size,
	input  logic [MAX_ORDER-1:0]           block_offset,
	input  logic [$clog2(MAX_ORDER+1)-1:0] pool_order,
	input  logic                           init_active,
	output logic                           busy,
	output logic                           rd_en,
	output logic [MAX_ORDER:0]             rd_addr,
	input  bma_pkg::node_t                 rd_data,
	output logic                           wr_en,
	output logic [MAX_ORDER:0]             wr_addr,
	output bma_pkg::node_t                 wr_data,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [MAX_ORDER-1:0]           granted_offset,
	output logic [MAX_ORDER:0]             granted_size,
	output logic [MAX_ORDER:0]             free_units
);

	localparam int IW = MAX_ORDER + 1;
	localparam int OFW = MAX_ORDER;
	localparam int SZW = MAX_ORDER + 1;
	localparam int OW = $clog2(MAX_ORDER + 1);
	localparam int AW = bma_pkg::AVAIL_W;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_A_DN, S_A_L, S_A_R, S_F_DN, S_F_W, S_U_RD, S_U_CMP, S_U_CLR
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   idx_q;
	logic [OW-1:0]   ord_q;
	logic [OW-1:0]   want_q;
	logic            op_q;
	logic            bad_q;
	logic [OFW-1:0]  off_q;
	logic [OFW-1:0]  base_q;
	bma_pkg::node_t  e_q;
	bma_pkg::node_t  cur_q;
	logic            done_q;
	logic [1:0]      status_q;
	logic [OFW-1:0]  goff_q;
	logic [SZW-1:0]  gsize_q;
	logic [SZW-1:0]  free_cnt_q;

	logic [SZW-1:0]  pool;
	logic [AW-1:0]   want_code;
	logic [OFW-1:0]  off_sh;
	logic [OFW-1:0]  low_mask;
	logic            merge;
	logic            left_fits;
	bma_pkg::node_t  up_node;

	function automatic logic [OW-1:0] ceil_log2(input logic [SZW-1:0] k);
		logic [SZW-1:0] km1;
		logic [OW-1:0]  w;
		km1 = k - 1'b1;
		w = '0;
		for (int i = 0; i < SZW; i++) begin
			if (km1[i]) begin
				w = OW'(i + 1);
			end
		end
		return w;
	endfunction

	assign pool = SZW'(1) << pool_order;
	assign want_code = AW'(want_q) + 1'b1;
	assign off_sh = off_q >> (ord_q - 1'b1);
	assign low_mask = (OFW'(1) << ord_q) - 1'b1;
	assign merge = (cur_q.st == bma_pkg::NODE_FREE) && (rd_data.st == bma_pkg::NODE_FREE);
	assign left_fits = rd_data.avail >= want_code;

	always_comb begin
		up_node.st = bma_pkg::NODE_SPLIT;
		up_node.avail = (cur_q.avail > rd_data.avail) ? cur_q.avail : rd_data.avail;
	end

	// memory port requests
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		case (state_q)
			S_IDLE: begin
				rd_en = go;
				rd_addr = IW'(1);
			end
			S_A_DN: begin
				if (e_q.st == bma_pkg::NODE_FREE && ord_q != want_q) begin
					wr_en = 1'b1;
					wr_addr = {idx_q[IW-2:0], 1'b1};
					wr_data.st = bma_pkg::NODE_FREE;
					wr_data.avail = AW'(ord_q);
				end else if (e_q.st == bma_pkg::NODE_SPLIT) begin
					rd_en = 1'b1;
					rd_addr = {idx_q[IW-2:0], 1'b0};
				end
			end
			S_A_L: begin
				if (!left_fits) begin
					rd_en = 1'b1;
					rd_addr = {idx_q[IW-2:0], 1'b1};
				end
			end
			S_F_DN: begin
				if (e_q.st == bma_pkg::NODE_SPLIT && ord_q != '0) begin
					rd_en = 1'b1;
					rd_addr = {idx_q[IW-2:0], off_sh[0]};
				end
			end
			S_U_RD: begin
				if (idx_q == IW'(1)) begin
					wr_en = 1'b1;
					wr_data = cur_q;
				end else begin
					rd_en = 1'b1;
					rd_addr = {idx_q[IW-1:1], ~idx_q[0]};
				end
			end
			S_U_CMP: begin
				wr_en = 1'b1;
				wr_data = merge ? '0 : cur_q;
			end
			S_U_CLR: begin
				wr_en = 1'b1;
				wr_addr = {idx_q[IW-1:1], ~idx_q[0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			ord_q <= '0;
			want_q <= '0;
			op_q <= bma_pkg::OP_ALLOC;
			bad_q <= 1'b0;
			off_q <= '0;
			base_q <= '0;
			e_q <= '0;
			cur_q <= '0;
			done_q <= 1'b0;
			status_q <= bma_pkg::ST_OK;
			goff_q <= '0;
			gsize_q <= '0;
			free_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (init_active) begin
				free_cnt_q <= pool;
			end
			case (state_q)
				S_IDLE: begin
					if (go) begin
						op_q <= op;
						off_q <= block_offset;
						want_q <= ceil_log2(request_size);
						bad_q <= (request_size == '0) || (request_size > pool);
						idx_q <= IW'(1);
						ord_q <= pool_order;
						base_q <= '0;
						status_q <= bma_pkg::ST_OK;
						goff_q <= '0;
						gsize_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					e_q <= rd_data;
					if (op_q == bma_pkg::OP_ALLOC) begin
						if (bad_q || rd_data.avail < want_code) begin
							status_q <= bma_pkg::ST_NOSPACE;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_A_DN;
						end
					end else if ({1'b0, off_q} >= pool) begin
						status_q <= bma_pkg::ST_BADFREE;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_F_DN;
					end
				end
				S_A_DN: begin
					if (e_q.st == bma_pkg::NODE_FREE) begin
						if (ord_q == want_q) begin
							cur_q.st <= bma_pkg::NODE_OCC;
							cur_q.avail <= '0;
							goff_q <= base_q;
							gsize_q <= SZW'(1) << ord_q;
							free_cnt_q <= free_cnt_q - (SZW'(1) << ord_q);
							state_q <= S_U_RD;
						end else begin
							// split: right half written free, keep walking the left half
							idx_q <= {idx_q[IW-2:0], 1'b0};
							ord_q <= ord_q - 1'b1;
							e_q.avail <= AW'(ord_q);
						end
					end else if (e_q.st == bma_pkg::NODE_SPLIT) begin
						state_q <= S_A_L;
					end else begin
						status_q <= bma_pkg::ST_NOSPACE;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_A_L: begin
					if (left_fits) begin
						e_q <= rd_data;
						idx_q <= {idx_q[IW-2:0], 1'b0};
						ord_q <= ord_q - 1'b1;
						state_q <= S_A_DN;
					end else begin
						state_q <= S_A_R;
					end
				end
				S_A_R: begin
					e_q <= rd_data;
					idx_q <= {idx_q[IW-2:0], 1'b1};
					base_q <= base_q + (OFW'(1) << (ord_q - 1'b1));
					ord_q <= ord_q - 1'b1;
					state_q <= S_A_DN;
				end
				S_F_DN: begin
					if (e_q.st == bma_pkg::NODE_SPLIT && ord_q != '0) begin
						idx_q <= {idx_q[IW-2:0], off_sh[0]};
						ord_q <= ord_q - 1'b1;
						state_q <= S_F_W;
					end else if (e_q.st == bma_pkg::NODE_OCC && (off_q & low_mask) == '0) begin
						cur_q.st <= bma_pkg::NODE_FREE;
						cur_q.avail <= AW'(ord_q) + 1'b1;
						free_cnt_q <= free_cnt_q + (SZW'(1) << ord_q);
						state_q <= S_U_RD;
					end else begin
						status_q <= bma_pkg::ST_BADFREE;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_F_W: begin
					e_q <= rd_data;
					state_q <= S_F_DN;
				end
				S_U_RD: begin
					if (idx_q == IW'(1)) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_U_CMP;
					end
				end
				S_U_CMP: begin
					if (merge) begin
						state_q <= S_U_CLR;
					end else begin
						cur_q <= up_node;
						idx_q <= idx_q >> 1;
						state_q <= S_U_RD;
					end
				end
				S_U_CLR: begin
					cur_q.avail <= cur_q.avail + 1'b1;
					idx_q <= idx_q >> 1;
					state_q <= S_U_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign granted_offset = goff_q;
	assign granted_size = gsize_q;
	assign free_units = free_cnt_q;

	`BMA_NEXT(a_done_single, done_q, !done_q, "result strobe held longer than one cycle")
	`BMA_CHECK(a_port_excl, !(rd_en && wr_en), "walker reads and writes in one cycle")
	`BMA_IMPLY(a_no_node0, wr_en, wr_addr != '0, "write to unused node zero")
	`BMA_IMPLY(a_free_bound, !init_active, free_cnt_q <= pool, "free count above pool size")
	`BMA_IMPLY(a_grant_pow2, done_q && status_q == bma_pkg::ST_OK && op_q == bma_pkg::OP_ALLOC,
		$onehot(gsize_q), "granted size not a power of two")

endmodule

[hdl/buddy_memory_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_memory_allocator
// Binary buddy allocator over a pool of 2^total_order units.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a clock edge with start high and busy low:
//   op 0 allocates request_size units, op 1 frees the block at block_offset.
//   Each command gives exactly one result, shown for one cycle with done high:
//   status, granted_offset, granted_size and the free_units left in the pool.
//   The receiver cannot stall; it must take the result in that cycle.
//   A command first reads the root node, where a bad request can already be
//   rejected. An allocate or a free then walks down the tree level by level
//   and, on success, climbs back to the root, fixing the subtree summaries.
//   The node memory port serializes the walk, one command at a time; the
//   result cycle already accepts the next. After reset, and after every
//   write of total_order (cfg_we), a clearing pass over all 2^(MAX_ORDER+1)
//   nodes rebuilds the tree as one free block; busy stays high through it.
//   Write total_order only while idle.
// ----------------------------------------------------------------------------
module buddy_memory_allocator #(
	parameter int MAX_ORDER = bma_pkg::DEF_MAX_ORDER
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bma_pkg::CFG_W-1:0]   total_order,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [MAX_ORDER:0]          request_size,
	input  logic [MAX_ORDER-1:0]        block_offset,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [MAX_ORDER-1:0]        granted_offset,
	output logic [MAX_ORDER:0]          granted_size,
	output logic [MAX_ORDER:0]          free_units
);

	localparam int IW = MAX_ORDER + 1;
	localparam int OW = $clog2(MAX_ORDER + 1);
	localparam int RESET_ORDER =
		(bma_pkg::CFG_RESET_ORDER > MAX_ORDER) ? MAX_ORDER : bma_pkg::CFG_RESET_ORDER;

	logic [OW-1:0]  order_q;
	logic           init_active;
	logic           init_we;
	logic [IW-1:0]  init_addr;
	bma_pkg::node_t init_data;
	logic           walk_busy;
	logic           walk_rd_en;
	logic [IW-1:0]  walk_rd_addr;
	logic           walk_we;
	logic [IW-1:0]  walk_addr;
	bma_pkg::node_t walk_data;
	bma_pkg::node_t ram_rdata;
	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	bma_pkg::node_t ram_wdata;

	// saturate the order to what the tree can hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= OW'(RESET_ORDER);
		end else if (cfg_we) begin
			if (int'(total_order) > MAX_ORDER) begin
				order_q <= OW'(MAX_ORDER);
			end else begin
				order_q <= OW'(total_order);
			end
		end
	end

	// clearing pass owns the write port while active
	always_comb begin
		if (init_active) begin
			ram_we = init_we;
			ram_waddr = init_addr;
			ram_wdata = init_data;
		end else begin
			ram_we = walk_we;
			ram_waddr = walk_addr;
			ram_wdata = walk_data;
		end
	end

	assign busy = init_active | walk_busy;

	bma_init #(
		.MAX_ORDER(MAX_ORDER)
	) u_init (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_we),
		.pool_order(order_q),
		.active(init_active),
		.wr_en(init_we),
		.wr_addr(init_addr),
		.wr_data(init_data)
	);

	bma_walk #(
		.MAX_ORDER(MAX_ORDER)
	) u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.go(start & ~busy),
		.op(op),
		.request_size(request_size),
		.block_offset(block_offset),
		.pool_order(order_q),
		.init_active(init_active),
		.busy(walk_busy),
		.rd_en(walk_rd_en),
		.rd_addr(walk_rd_addr),
		.rd_data(ram_rdata),
		.wr_en(walk_we),
		.wr_addr(walk_addr),
		.wr_data(walk_data),
		.done(done),
		.status(status),
		.granted_offset(granted_offset),
		.granted_size(granted_size),
		.free_units(free_units)
	);

	bma_ram #(
		.WIDTH(bma_pkg::NODE_W),
		.DEPTH(2 ** IW)
	) u_nodes (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(walk_rd_en),
		.raddr(walk_rd_addr),
		.rdata(ram_rdata)
	);

endmodule
